// File: design/nearest_point_search_defines.svh
// ----------------------------------------------------------------------------
// nearest point search assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH

// same-cycle implication, reset masked
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// shared types and constants of the nearest point search block
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_WIDTH_DEF = 16;

    // apb port
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam int REG_SEL_BIT = 3;

    // register select (one 64-bit register per 8 bytes)
    localparam logic REG_REF_COUNT = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    // 100.0 with 16 fraction bits
    localparam logic [PDATA_W-1:0] THRESH_RESET_VAL = 64'd6553600;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // marks on a word travelling down the cell chain
    typedef struct packed {
        logic live;  // slot carries a word
        logic hit;   // word holds a stored point
        logic last;  // final word of the query
    } tag_t;

endpackage

// File: design/nps_point_store.sv
// ----------------------------------------------------------------------------
// nps_point_store
// single-port-write, single-port-read point memory with registered read
// ----------------------------------------------------------------------------
module nps_point_store #(
    parameter int DEPTH  = nps_pkg::MAX_POINTS_DEF,
    parameter int WORD_W = 3 * nps_pkg::COORD_WIDTH_DEF,
    parameter int ADDR_W = $clog2(nps_pkg::MAX_POINTS_DEF)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/nps_axis_cell.sv
// ----------------------------------------------------------------------------
// nps_axis_cell
// one link of the distance chain: adds the squared difference on one axis
// ----------------------------------------------------------------------------
module nps_axis_cell #(
    parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF,
    parameter int IDX_W       = $clog2(nps_pkg::MAX_POINTS_DEF),
    parameter int AXIS        = 0,
    localparam int DIST_W     = 2 * COORD_WIDTH + 2,
    localparam int WORD_W     = 3 * COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COORD_WIDTH-1:0] query,
    input  logic [WORD_W-1:0]      point_in,
    input  nps_pkg::tag_t          tag_in,
    input  logic [IDX_W-1:0]       idx_in,
    input  logic [DIST_W-1:0]      sum_in,
    output logic [WORD_W-1:0]      point_out,
    output nps_pkg::tag_t          tag_out,
    output logic [IDX_W-1:0]       idx_out,
    output logic [DIST_W-1:0]      sum_out
);
    import nps_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;

    logic [COORD_WIDTH-1:0]   ref_coord;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIST_W-1:0] prod;

    // stage one: square
    logic [DIST_W-1:0] sq_reg;
    logic [DIST_W-1:0] sum_d_reg;
    logic [WORD_W-1:0] point_d_reg;
    logic [IDX_W-1:0]  idx_d_reg;
    tag_t              tag_d_reg;

    // stage two: accumulate
    logic [DIST_W-1:0] sum_out_reg;
    logic [WORD_W-1:0] point_out_reg;
    logic [IDX_W-1:0]  idx_out_reg;
    tag_t              tag_out_reg;

    assign ref_coord = point_in[AXIS*COORD_WIDTH +: COORD_WIDTH];
    assign diff = {query[COORD_WIDTH-1], query} - {ref_coord[COORD_WIDTH-1], ref_coord};
    assign prod = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg   <= '0;
            tag_out_reg <= '0;
        end
        else
        begin
            tag_d_reg   <= tag_in;
            tag_out_reg <= tag_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg        <= prod;
        sum_d_reg     <= sum_in;
        point_d_reg   <= point_in;
        idx_d_reg     <= idx_in;
        sum_out_reg   <= sum_d_reg + sq_reg;
        point_out_reg <= point_d_reg;
        idx_out_reg   <= idx_d_reg;
    end

    assign point_out = point_out_reg;
    assign tag_out   = tag_out_reg;
    assign idx_out   = idx_out_reg;
    assign sum_out   = sum_out_reg;

endmodule

// File: design/nps_min_tracker.sv
// ----------------------------------------------------------------------------
// nps_min_tracker
// end of the chain: keeps the running minimum and issues the result word
// ----------------------------------------------------------------------------
module nps_min_tracker #(
    parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF,
    parameter int IDX_W       = $clog2(nps_pkg::MAX_POINTS_DEF),
    localparam int DIST_W     = 2 * COORD_WIDTH + 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              init,
    input  logic [DIST_W-1:0] threshold,
    input  nps_pkg::tag_t     tag_in,
    input  logic [IDX_W-1:0]  idx_in,
    input  logic [DIST_W-1:0] sum_in,
    output logic              done,
    output logic [IDX_W-1:0]  nearest_index,
    output logic [DIST_W-1:0] sq_distance
);
    import nps_pkg::*;

    logic [DIST_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] dist_out_reg;
    logic [IDX_W-1:0]  idx_out_reg;
    logic              done_reg;

    logic              take;
    logic              finish;
    logic [DIST_W-1:0] best_next;
    logic [IDX_W-1:0]  best_idx_next;

    // strict less-than keeps the first of equal minima
    assign take   = tag_in.live && tag_in.hit && (sum_in < best_reg);
    assign finish = tag_in.live && tag_in.last;

    always_comb
    begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (take)
        begin
            best_next     = sum_in;
            best_idx_next = idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            best_reg     <= threshold;
            best_idx_reg <= '0;
        end
        else
        begin
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
        if (finish)
        begin
            dist_out_reg <= best_next;
            idx_out_reg  <= best_idx_next;
        end
    end

    assign done          = done_reg;
    assign nearest_index = idx_out_reg;
    assign sq_distance   = dist_out_reg;

endmodule

// File: design/nearest_point_search.sv
// ----------------------------------------------------------------------------
// nearest_point_search
// brute-force 3d nearest neighbor over a store of reference points
// ----------------------------------------------------------------------------
// load word: written to the store at accept, no result, next word the cycle after
// query word: N store reads run through the axis cells to the tracker, then a strobe;
//   N = searched count (ref_count saturated at the store depth, zero allowed)
// next word taken once busy drops after the strobe; one store read per cycle feeds the chain
// reset: async active low, clears control, ref_count / threshold to defaults;
//   the point store holds nothing defined until loaded
module nearest_point_search #(
    parameter int MAX_POINTS  = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF,
    localparam int IDX_W      = $clog2(MAX_POINTS),
    localparam int CNT_W      = $clog2(MAX_POINTS + 1),
    localparam int DIST_W     = 2 * COORD_WIDTH + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [IDX_W-1:0]             point_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    // result channel
    output logic                         done,
    output logic [IDX_W-1:0]             nearest_index,
    output logic [DIST_W-1:0]            sq_distance,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nps_pkg::PADDR_W-1:0]  paddr,
    input  logic [nps_pkg::PDATA_W-1:0]  pwdata,
    output logic [nps_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import nps_pkg::*;

    localparam int WORD_W = 3 * COORD_WIDTH;
    localparam int NCELLS = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // configuration registers
    logic [CNT_W-1:0]  ref_count_reg;
    logic [DIST_W-1:0] thresh_reg;
    logic              cfg_write;

    // sequencer
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  last_addr_reg, last_addr_next;
    tag_t              rd_tag_reg, rd_tag_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    // latched query point
    logic [COORD_WIDTH-1:0] qx_reg, qy_reg, qz_reg;

    logic              accept;
    logic              query_accept;
    logic              load_wr;
    logic [CNT_W-1:0]  count_eff;
    logic [WORD_W-1:0] rd_word;
    logic [COORD_WIDTH-1:0] query_coord [NCELLS];

    // chain links, one more than cells
    logic [WORD_W-1:0] point_chain [NCELLS+1];
    tag_t              tag_chain   [NCELLS+1];
    logic [IDX_W-1:0]  idx_chain   [NCELLS+1];
    logic [DIST_W-1:0] sum_chain   [NCELLS+1];

    assign accept       = start && !busy;
    assign query_accept = accept && (op == OP_QUERY);

    // loads past the store depth are dropped
    assign load_wr = accept && (op == OP_LOAD)
                     && ({1'b0, point_index} < CNT_W'(MAX_POINTS));

    // searched count saturates at the store depth
    assign count_eff = (ref_count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                            : ref_count_reg;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= CNT_W'(MAX_POINTS);
            thresh_reg    <= THRESH_RESET_VAL[DIST_W-1:0];
        end
        else if (cfg_write)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_REF_COUNT: ref_count_reg <= pwdata[CNT_W-1:0];
                REG_THRESHOLD: thresh_reg    <= pwdata[DIST_W-1:0];
                default:       ref_count_reg <= ref_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_REF_COUNT: prdata = PDATA_W'(ref_count_reg);
            REG_THRESHOLD: prdata = PDATA_W'(thresh_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- scan sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_addr_next = last_addr_reg;
        rd_tag_next    = '0;
        rd_idx_next    = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    addr_next      = '0;
                    last_addr_next = IDX_W'(count_eff - CNT_W'(1));
                    if (count_eff == '0)
                    begin
                        // empty search: one marker word carries the threshold out
                        rd_tag_next = '{live: 1'b1, hit: 1'b0, last: 1'b1};
                        state_next  = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_tag_next = '{live: 1'b1, hit: 1'b1, last: (addr_reg == last_addr_reg)};
                if (addr_reg == last_addr_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // result strobe ends the query
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            last_addr_reg <= '0;
            rd_tag_reg    <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            last_addr_reg <= last_addr_next;
            rd_tag_reg    <= rd_tag_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // query point stays put for the whole scan
    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            qz_reg <= coord_z;
        end
    end

    // ---------------- point store ----------------
    nps_point_store #(
        .DEPTH  (MAX_POINTS),
        .WORD_W (WORD_W),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (point_index),
        .wr_data ({coord_z, coord_y, coord_x}),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (addr_reg),
        .rd_data (rd_word)
    );

    // ---------------- distance chain ----------------
    // cell k adds the squared difference on axis k (x, y, z)
    assign query_coord[0] = qx_reg;
    assign query_coord[1] = qy_reg;
    assign query_coord[2] = qz_reg;

    assign point_chain[0] = rd_word;
    assign tag_chain[0]   = rd_tag_reg;
    assign idx_chain[0]   = rd_idx_reg;
    assign sum_chain[0]   = '0;

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        nps_axis_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .IDX_W       (IDX_W),
            .AXIS        (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query_coord[g]),
            .point_in  (point_chain[g]),
            .tag_in    (tag_chain[g]),
            .idx_in    (idx_chain[g]),
            .sum_in    (sum_chain[g]),
            .point_out (point_chain[g+1]),
            .tag_out   (tag_chain[g+1]),
            .idx_out   (idx_chain[g+1]),
            .sum_out   (sum_chain[g+1])
        );
    end

    // ---------------- minimum and result word ----------------
    nps_min_tracker #(
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W)
    ) u_min (
        .clk           (clk),
        .rst_n         (rst_n),
        .init          (query_accept),
        .threshold     (thresh_reg),
        .tag_in        (tag_chain[NCELLS]),
        .idx_in        (idx_chain[NCELLS]),
        .sum_in        (sum_chain[NCELLS]),
        .done          (done),
        .nearest_index (nearest_index),
        .sq_distance   (sq_distance)
    );

endmodule

// File: design/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// port-level checks of the command and result handshake over time
// ----------------------------------------------------------------------------
`include "nearest_point_search_defines.svh"

module nps_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic op,
    input logic done
);
    import nps_pkg::*;

    // a result word only ends a running query
    `NPS_ASSERT_NOW(a_done_in_query, done, busy, "result word outside a query")
    // a query holds the command side until its result
    `NPS_ASSERT_NEXT(a_query_busy, start && !busy && (op == OP_QUERY), busy, "query not held")
    // a load never blocks the next word
    `NPS_ASSERT_NEXT(a_load_free, start && !busy && (op == OP_LOAD), !busy, "load held busy")
    // exactly one result per query, then idle
    `NPS_ASSERT_NEXT(a_single_result, done, !done && !busy, "extra result or stuck busy")

endmodule

bind nearest_point_search nps_checker u_nps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for nearest_point_search: loads reference points,
// sends queries and compares every nearest index / squared distance with a
// local brute-force predictor, over several register settings and idle mixes
// ----------------------------------------------------------------------------
module tb;
    import nps_pkg::*;

    localparam int NPTS       = MAX_POINTS_DEF;
    localparam int CW         = COORD_WIDTH_DEF;
    localparam int IDX_W      = $clog2(NPTS);
    localparam int CNT_W      = $clog2(NPTS + 1);
    localparam int DIST_W     = 2 * CW + 2;
    // loaded prefix of the store; no search goes past it
    localparam int NFILL      = 256;
    // longest quiet stretch: loaded-range scan, sender gap, drain and bus writes
    localparam int QUIET_LIMIT = 5000;
    // expected words in flight, one query at a time
    localparam int EXP_DEPTH  = 8;

    localparam logic signed [CW-1:0] C_MIN    = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX    = {1'b0, {(CW-1){1'b1}}};
    localparam logic [DIST_W-1:0]    DIST_TOP = '1;
    localparam logic [DIST_W-1:0]    DIST_DEF = THRESH_RESET_VAL[DIST_W-1:0];

    // how a coordinate is drawn
    typedef enum int {
        C_FULL,
        C_SHORT,
        C_RAIL,
        C_NEAR
    } coord_mode_t;

    // one expected result word
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] sq_dist;
    } nearest_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   op = 1'b0;
    logic [IDX_W-1:0]       point_index = '0;
    logic signed [CW-1:0]   coord_x = '0;
    logic signed [CW-1:0]   coord_y = '0;
    logic signed [CW-1:0]   coord_z = '0;
    logic                   done;
    logic [IDX_W-1:0]       nearest_index;
    logic [DIST_W-1:0]      sq_distance;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // predictor copy of the point store and of the registers
    logic signed [CW-1:0]   ref_x [NPTS];
    logic signed [CW-1:0]   ref_y [NPTS];
    logic signed [CW-1:0]   ref_z [NPTS];
    logic [CNT_W-1:0]       cfg_count = CNT_W'(NPTS);
    logic [DIST_W-1:0]      cfg_thresh = DIST_DEF;

    // ring of expected words, write and read counts
    nearest_t               exp_ring [EXP_DEPTH];
    int unsigned            exp_wr = 0;
    int unsigned            exp_rd = 0;
    int unsigned            mismatches = 0;
    int unsigned            quiet_cycles = 0;
    int unsigned            idle_pct = 0;

    nearest_point_search DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .point_index   (point_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .done          (done),
        .nearest_index (nearest_index),
        .sq_distance   (sq_distance),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // searched entries after saturation at the store size
    function automatic int unsigned scan_len();
        return (cfg_count > NPTS) ? NPTS : int'(cfg_count);
    endfunction

    // brute-force scan, strict less-than so the first of equal minima wins
    function automatic nearest_t nearest_of(input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] z);
        nearest_t    best;
        longint      dx;
        longint      dy;
        longint      dz;
        logic [63:0] d;
        best.index   = '0;
        best.sq_dist = cfg_thresh;
        for (int unsigned j = 0; j < scan_len(); j++)
        begin
            dx = longint'(x) - longint'(ref_x[j]);
            dy = longint'(y) - longint'(ref_y[j]);
            dz = longint'(z) - longint'(ref_z[j]);
            d  = dx * dx + dy * dy + dz * dz;
            if (d < 64'(best.sq_dist))
            begin
                best.sq_dist = d[DIST_W-1:0];
                best.index   = IDX_W'(j);
            end
        end
        return best;
    endfunction

    function automatic logic signed [CW-1:0] random_coord(input coord_mode_t mode,
                                                          input logic signed [CW-1:0] base);
        int v;
        case (mode)
            C_SHORT:
                return CW'(int'($urandom_range(0, 4095)) - 2048);
            C_RAIL:
                case ($urandom_range(0, 3))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            C_NEAR:
            begin
                v = int'(base) + int'($urandom_range(0, 1200)) - 600;
                if (v < int'(C_MIN))
                    v = int'(C_MIN);
                if (v > int'(C_MAX))
                    v = int'(C_MAX);
                return CW'(v);
            end
            default:
                return CW'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // one command word: random idle gap, then hold start until busy is low
    task automatic send_word(input op_t kind, input logic [IDX_W-1:0] idx,
                             input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
        logic taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            // junk on the fields while start is low
            start       <= 1'b0;
            op          <= 1'($urandom_range(0, 1));
            point_index <= IDX_W'($urandom);
            coord_x     <= CW'($urandom);
            @(posedge clk);
        end
        start       <= 1'b1;
        op          <= kind;
        point_index <= idx;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        // busy is stable at the falling edge, accept happens at the next rise
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        if (kind == OP_LOAD)
        begin
            ref_x[idx] = x;
            ref_y[idx] = y;
            ref_z[idx] = z;
        end
        else
        begin
            exp_ring[exp_wr % EXP_DEPTH] = nearest_of(x, y, z);
            exp_wr++;
        end
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (exp_wr != exp_rd)
            @(posedge clk);
        // busy drops in the cycle after the strobe, the rest is margin
        repeat (16) @(posedge clk);
    endtask

    // setup then access phase, then the bus returns to idle
    task automatic reg_write(input logic sel, input logic [PDATA_W-1:0] data);
        logic ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(sel) << REG_SEL_BIT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end
        while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (sel == REG_REF_COUNT)
            cfg_count = data[CNT_W-1:0];
        else
            cfg_thresh = data[DIST_W-1:0];
    endtask

    // both registers, junk above the register width to check masking
    task automatic set_config(input logic [CNT_W-1:0] count, input logic [DIST_W-1:0] thresh);
        logic [PDATA_W-1:0] data;
        wait_drained();
        data = {$urandom, $urandom};
        data[CNT_W-1:0] = count;
        reg_write(REG_REF_COUNT, data);
        data = {$urandom, $urandom};
        data[DIST_W-1:0] = thresh;
        reg_write(REG_THRESHOLD, data);
    endtask

    // ------------------------------------------------------------------------
    // result checker: done marks a word for exactly one cycle
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        nearest_t want;
        if (rst_n && done)
        begin
            if (exp_wr == exp_rd)
            begin
                mismatches++;
                $display("%0t: result with no query pending: index %0d dist %0d",
                         $time, nearest_index, sq_distance);
            end
            else
            begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (nearest_index !== want.index)
                begin
                    mismatches++;
                    $display("%0t: nearest_index expected %0d actual %0d",
                             $time, want.index, nearest_index);
                end
                if (sq_distance !== want.sq_dist)
                begin
                    mismatches++;
                    $display("%0t: sq_distance expected %0d actual %0d",
                             $time, want.sq_dist, sq_distance);
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(negedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** nearest_point_search: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // fill the first NFILL entries and search exactly those; the threshold
    // keeps its reset value (100.0)
    task automatic test_reset_fill();
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        idle_pct = 0;
        reg_write(REG_REF_COUNT, PDATA_W'(NFILL));
        for (int i = 0; i < NFILL; i++)
        begin
            x = random_coord(C_FULL, '0);
            y = random_coord(C_SHORT, '0);
            z = random_coord(C_FULL, '0);
            if (i == NFILL - 1)
            begin
                x = C_MIN;
                y = C_MAX;
                z = C_MIN;
            end
            send_word(OP_LOAD, IDX_W'(i), x, y, z);
        end
        // exact hit deep in the store, then a point a short way off entry 3
        send_word(OP_QUERY, IDX_W'(NPTS - 1), ref_x[200], ref_y[200], ref_z[200]);
        send_word(OP_QUERY, '0, ref_x[3] + 16'sd300, ref_y[3], ref_z[3] - 16'sd200);
    endtask

    // coordinate rails, ties between equal entries, the largest distance
    task automatic test_extremes();
        set_config(CNT_W'(4), DIST_TOP);
        send_word(OP_LOAD, IDX_W'(0), C_MIN, C_MIN, C_MIN);
        send_word(OP_LOAD, IDX_W'(1), C_MAX, C_MAX, C_MAX);
        send_word(OP_LOAD, IDX_W'(2), '0, '0, '0);
        send_word(OP_LOAD, IDX_W'(3), C_MIN, C_MIN, C_MIN);
        send_word(OP_QUERY, '1, C_MAX, C_MAX, C_MAX);
        // equal minima at 0 and 3: the first one wins
        send_word(OP_QUERY, '0, C_MIN, C_MIN, C_MIN);
        send_word(OP_QUERY, '1, '0, '0, '0);
        send_word(OP_QUERY, '0, C_MAX, C_MIN, '0);
        // one entry, opposite corner: 3 * 65535^2, the top of the range
        set_config(CNT_W'(1), DIST_TOP);
        send_word(OP_QUERY, '1, C_MAX, C_MAX, C_MAX);
    endtask

    // distance equal to the threshold does not count as a hit
    task automatic test_threshold_edges();
        set_config(CNT_W'(3), DIST_DEF);
        send_word(OP_LOAD, IDX_W'(0), '0, '0, '0);
        send_word(OP_LOAD, IDX_W'(1), C_MAX, C_MAX, C_MAX);
        send_word(OP_LOAD, IDX_W'(2), C_MIN, C_MIN, C_MIN);
        // 10.0 away in x gives exactly 100.0
        send_word(OP_QUERY, '0, 16'sd2560, '0, '0);
        send_word(OP_QUERY, '0, 16'sd2559, '0, '0);
        // zero threshold: even an exact hit falls back to index 0
        set_config(CNT_W'(3), '0);
        send_word(OP_QUERY, '1, C_MAX, C_MAX, C_MAX);
    endtask

    // empty search, the whole loaded range under both thresholds
    task automatic test_count_edges();
        set_config('0, DIST_TOP);
        send_word(OP_QUERY, '0, '0, '0, '0);
        set_config(CNT_W'(NFILL), DIST_DEF);
        send_word(OP_QUERY, '1, ref_x[NFILL - 50], ref_y[NFILL - 50], ref_z[NFILL - 50]);
        set_config(CNT_W'(NFILL), DIST_TOP);
        send_word(OP_QUERY, '0, C_MAX, C_MIN, C_MAX);
    endtask

    // mixed loads and queries; most queries land near a searched entry so
    // the minimum moves away from the threshold
    task automatic test_random_traffic(input int unsigned pct, input int unsigned blocks);
        logic [CNT_W-1:0]     count;
        logic [DIST_W-1:0]    thresh;
        int unsigned          n;
        int unsigned          j;
        int unsigned          r;
        logic [IDX_W-1:0]     idx;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        coord_mode_t          mode;
        idle_pct = pct;
        for (int unsigned b = 0; b < blocks; b++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                count = '0;
            else if (r < 9)
                count = CNT_W'(NFILL);
            else
                count = CNT_W'($urandom_range(1, 40));
            r = $urandom_range(0, 99);
            if (r < 30)
                thresh = DIST_DEF;
            else if (r < 50)
                thresh = DIST_TOP;
            else if (r < 70)
                thresh = DIST_W'($urandom_range(0, 2000000));
            else if (r < 80)
                thresh = '0;
            else
                thresh = {2'($urandom), 32'($urandom)};
            set_config(count, thresh);
            n = scan_len();
            for (int unsigned k = 0; k < 25; k++)
            begin
                // occasional full stop until the block has nothing left
                if ($urandom_range(0, 99) < 4)
                    wait_drained();
                j = (n == 0) ? 0 : $urandom_range(0, n - 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    // load, mostly inside or just past the searched range
                    if ($urandom_range(0, 99) < 75)
                        idx = IDX_W'($urandom_range(0, (n + 7 > NPTS - 1) ? NPTS - 1 : n + 7));
                    else
                        idx = IDX_W'($urandom);
                    r = $urandom_range(0, 99);
                    if (r < 10)
                    begin
                        // duplicate of an entry: sets up equal minima
                        x = ref_x[j];
                        y = ref_y[j];
                        z = ref_z[j];
                    end
                    else
                    begin
                        mode = (r < 30) ? C_RAIL : (r < 60) ? C_SHORT : C_FULL;
                        x = random_coord(mode, '0);
                        y = random_coord(mode, '0);
                        z = random_coord(mode, '0);
                    end
                    send_word(OP_LOAD, idx, x, y, z);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60 && n != 0)
                        mode = C_NEAR;
                    else if (r < 85)
                        mode = C_FULL;
                    else
                        mode = C_RAIL;
                    x = random_coord(mode, ref_x[j]);
                    y = random_coord(mode, ref_y[j]);
                    z = random_coord(mode, ref_z[j]);
                    send_word(OP_QUERY, IDX_W'($urandom), x, y, z);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            ref_x[i] = '0;
            ref_y[i] = '0;
            ref_z[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_fill();
        test_extremes();
        test_threshold_edges();
        test_count_edges();
        // receiver side cannot stall, so only the sender idles
        test_random_traffic(0, 4);
        test_random_traffic(46, 4);
        test_random_traffic(31, 4);

        wait_drained();
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("** nearest_point_search: PASSED **");
        else
            $display("** nearest_point_search: FAILED **");
        $finish;
    end

endmodule

// File: nearest_point_search.f
+incdir+design
design/nps_pkg.sv
design/nps_point_store.sv
design/nps_axis_cell.sv
design/nps_min_tracker.sv
design/nearest_point_search.sv
design/nps_checker.sv
bench/tb.sv
